// File: rtl/core/psg_pkg.sv
package psg_pkg;

  localparam int SAMPLE_RATE = 44100;

  localparam int FREQ_W   = 17;
  localparam int VOL_W    = 8;
  localparam int SAMPLE_W = 16;
  localparam int NUM_CH   = 4;
  localparam int NUM_TONE = 3;
  localparam int NOISE_CH = 3;

  localparam int FREQ_MAX  = (1 << FREQ_W) - 1;
  localparam int PHASE_W   = $clog2(SAMPLE_RATE);
  // phase + freq peaks at SAMPLE_RATE - 1 + FREQ_MAX
  localparam int SUM_W     = $clog2(SAMPLE_RATE + FREQ_MAX);
  localparam int MAX_WRAPS = (SAMPLE_RATE - 1 + FREQ_MAX) / SAMPLE_RATE;
  localparam int WRAP_W    = $clog2(MAX_WRAPS + 1);
  // 2*p < rate  <=>  p < ceil(rate/2)
  localparam int HALF_RATE = (SAMPLE_RATE + 1) / 2;

  localparam int AMP_SCALE = 30;
  localparam int AMP_W     = VOL_W + 5;
  localparam int MIX_W     = AMP_W + 4;

  localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [MIX_W-1:0] SAT_LO = -SAT_HI - MIX_W'(1);

  localparam int LFSR_W = 15;
  localparam logic [LFSR_W:0] LFSR_SEED = (LFSR_W + 1)'(1 << LFSR_W);

  typedef struct packed {
    logic             active;
    logic             positive;
    logic [VOL_W-1:0] vol;
  } chan_term_t;

  function automatic logic [AMP_W-1:0] amp_f(logic [VOL_W-1:0] vol);
    return AMP_W'(32'(vol) * AMP_SCALE);
  endfunction

  // One LFSR shift; an all-zero register is reseeded before the shift.
  function automatic logic [LFSR_W-1:0] lfsr_adv(logic [LFSR_W-1:0] r);
    logic [LFSR_W:0] s;
    s = (r == '0) ? LFSR_SEED : {1'b0, r};
    return {s[LFSR_W] | (s[0] ^ s[3]), s[LFSR_W-1:1]};
  endfunction

endpackage

// File: rtl/core/psg_phase_acc.sv
module psg_phase_acc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [psg_pkg::FREQ_W-1:0]   freq_i,
  output logic [psg_pkg::PHASE_W-1:0]  phase_o,
  output logic [psg_pkg::WRAP_W-1:0]   wraps_o
);

  logic [psg_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [psg_pkg::SUM_W-1:0]   sum;
  logic [psg_pkg::WRAP_W-1:0]  wraps;

  // parallel compares against k*rate, highest hit wins
  always_comb begin
    sum     = psg_pkg::SUM_W'(phase_q) + psg_pkg::SUM_W'(freq_i);
    wraps   = '0;
    phase_d = psg_pkg::PHASE_W'(sum);
    for (int k = 1; k <= psg_pkg::MAX_WRAPS; k++) begin
      if (sum >= psg_pkg::SUM_W'(k * psg_pkg::SAMPLE_RATE)) begin
        wraps   = psg_pkg::WRAP_W'(k);
        phase_d = psg_pkg::PHASE_W'(sum - psg_pkg::SUM_W'(k * psg_pkg::SAMPLE_RATE));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_d;
  assign wraps_o = wraps;

endmodule

// File: rtl/core/psg_noise_lfsr.sv
module psg_noise_lfsr (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [psg_pkg::WRAP_W-1:0]  wraps_i,
  output logic                        bit_o
);

  logic [psg_pkg::LFSR_W-1:0] lfsr_q, lfsr_d;

  // one shift per phase wrap of this tick
  always_comb begin
    lfsr_d = lfsr_q;
    for (int k = 1; k <= psg_pkg::MAX_WRAPS; k++) begin
      if (psg_pkg::WRAP_W'(k) <= wraps_i) begin
        lfsr_d = psg_pkg::lfsr_adv(lfsr_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= '0;
    end else if (en_i) begin
      lfsr_q <= lfsr_d;
    end
  end

  assign bit_o = lfsr_d[0];

endmodule

// File: rtl/core/psg_mix_sat.sv
module psg_mix_sat (
  input  psg_pkg::chan_term_t           term_i [psg_pkg::NUM_CH],
  output logic [psg_pkg::SAMPLE_W-1:0]  sample_o
);

  logic signed [psg_pkg::MIX_W-1:0] mix;
  logic signed [psg_pkg::MIX_W-1:0] amp;

  always_comb begin
    mix = '0;
    amp = '0;
    for (int ch = 0; ch < psg_pkg::NUM_CH; ch++) begin
      amp = signed'(psg_pkg::MIX_W'(psg_pkg::amp_f(term_i[ch].vol)));
      if (term_i[ch].active) begin
        mix = term_i[ch].positive ? mix + amp : mix - amp;
      end
    end
  end

  always_comb begin
    if (mix > psg_pkg::SAT_HI) begin
      sample_o = psg_pkg::SAMPLE_W'(psg_pkg::SAT_HI);
    end else if (mix < psg_pkg::SAT_LO) begin
      sample_o = psg_pkg::SAMPLE_W'(psg_pkg::SAT_LO);
    end else begin
      sample_o = psg_pkg::SAMPLE_W'(mix);
    end
  end

endmodule

// File: rtl/core/psg_square_noise_mixer.sv
// Three square tones plus one LFSR noise channel, mixed to one sample per request.
// out_valid_o rises once an accepted request passes the input reg, then the result reg.
// Throughput: one request per cycle unless a held result is stalled (out_stall_i).
// Input stalls only while the input register is full and the result is stalled.
// Reset (rst_ni low, async) clears all phases, the LFSR and both valid flags.
module psg_square_noise_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [psg_pkg::FREQ_W-1:0]          tone_a_freq_i,
  input  logic [psg_pkg::FREQ_W-1:0]          tone_b_freq_i,
  input  logic [psg_pkg::FREQ_W-1:0]          tone_c_freq_i,
  input  logic [psg_pkg::FREQ_W-1:0]          noise_freq_i,
  input  logic [psg_pkg::VOL_W-1:0]           tone_a_vol_i,
  input  logic [psg_pkg::VOL_W-1:0]           tone_b_vol_i,
  input  logic [psg_pkg::VOL_W-1:0]           tone_c_vol_i,
  input  logic [psg_pkg::VOL_W-1:0]           noise_vol_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [psg_pkg::SAMPLE_W-1:0] sample_o
);

  logic                         in_valid_q;
  logic [psg_pkg::FREQ_W-1:0]   freq_q [psg_pkg::NUM_CH];
  logic [psg_pkg::VOL_W-1:0]    vol_q  [psg_pkg::NUM_CH];
  logic                         out_valid_q;
  logic [psg_pkg::SAMPLE_W-1:0] sample_q, sample_d;
  logic                         advance;
  logic [psg_pkg::NUM_CH-1:0]   active;
  logic [psg_pkg::PHASE_W-1:0]  phase [psg_pkg::NUM_CH];
  logic [psg_pkg::WRAP_W-1:0]   wraps [psg_pkg::NUM_CH];
  logic                         noise_bit;
  psg_pkg::chan_term_t          term [psg_pkg::NUM_CH];

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      freq_q[0] <= tone_a_freq_i;
      freq_q[1] <= tone_b_freq_i;
      freq_q[2] <= tone_c_freq_i;
      freq_q[3] <= noise_freq_i;
      vol_q[0]  <= tone_a_vol_i;
      vol_q[1]  <= tone_b_vol_i;
      vol_q[2]  <= tone_c_vol_i;
      vol_q[3]  <= noise_vol_i;
    end
  end

  for (genvar ch = 0; ch < psg_pkg::NUM_CH; ch++) begin : g_chan
    assign active[ch] = (freq_q[ch] != '0) && (vol_q[ch] != '0);

    psg_phase_acc u_phase (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance && active[ch]),
      .freq_i  (freq_q[ch]),
      .phase_o (phase[ch]),
      .wraps_o (wraps[ch])
    );

    assign term[ch].active = active[ch];
    assign term[ch].vol    = vol_q[ch];
    if (ch < psg_pkg::NUM_TONE) begin : g_tone
      assign term[ch].positive = phase[ch] < psg_pkg::PHASE_W'(psg_pkg::HALF_RATE);
    end else begin : g_noise
      assign term[ch].positive = noise_bit;
    end
  end

  psg_noise_lfsr u_noise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance && active[psg_pkg::NOISE_CH]),
    .wraps_i (wraps[psg_pkg::NOISE_CH]),
    .bit_o   (noise_bit)
  );

  psg_mix_sat u_mix (
    .term_i   (term),
    .sample_o (sample_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = signed'(sample_q);

endmodule

// File: rtl/core/psg_checker.sv
module psg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [psg_pkg::SAMPLE_W-1:0] sample_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled result changed");

  // input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // a fresh result stems from an accepted request that passed the input register, then the result register
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without request");

endmodule

bind psg_square_noise_mixer psg_checker u_psg_checker (.*);
